// File: hdl/thc_pkg.sv
`timescale 1ns / 1ps

package thc_pkg;

  // APB register file geometry: six 32-bit registers at word addresses.
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_TARGET_TEMP    = 3'd0;
  localparam logic [2:0] REG_SWING_BAND     = 3'd1;
  localparam logic [2:0] REG_REQUESTED_MODE = 3'd2;
  localparam logic [2:0] REG_FAN_FORCE      = 3'd3;
  localparam logic [2:0] REG_FLOOR_TEMP     = 3'd4;
  localparam logic [2:0] REG_FAN_DELAY_MS   = 3'd5;

  // Register reset values.
  localparam logic signed [15:0] FloorTempReset  = 16'sh8000;
  localparam logic [15:0]        FanDelayMsReset = 16'(30 * 1000);

  // Operating modes, shared by the requested and the active mode.
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_HEAT    = 2'd1,
    MODE_COOL    = 2'd2,
    MODE_INVALID = 2'd3
  } mode_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic signed [15:0] target_temp;
    logic [14:0]        swing_band;
    mode_e              requested_mode;
    logic               fan_force;
    logic signed [15:0] floor_temp;
    logic [15:0]        fan_delay_ms;
  } cfg_t;

  // One input beat held in the input register.
  typedef struct packed {
    logic signed [15:0] temperature;
    logic [31:0]        now_ms;
  } in_beat_t;

endpackage

// File: hdl/thc_apb_regs.sv
`timescale 1ns / 1ps

module thc_apb_regs
  import thc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrWidth-1:2];
  assign cfg_o   = cfg_q;

  // Register writes on the access cycle of an APB write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp    <= '0;
      cfg_q.swing_band     <= '0;
      cfg_q.requested_mode <= MODE_OFF;
      cfg_q.fan_force      <= 1'b0;
      cfg_q.floor_temp     <= FloorTempReset;
      cfg_q.fan_delay_ms   <= FanDelayMsReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET_TEMP:    cfg_q.target_temp    <= pwdata[15:0];
        REG_SWING_BAND:     cfg_q.swing_band     <= pwdata[14:0];
        REG_REQUESTED_MODE: cfg_q.requested_mode <= mode_e'(pwdata[1:0]);
        REG_FAN_FORCE:      cfg_q.fan_force      <= pwdata[0];
        REG_FLOOR_TEMP:     cfg_q.floor_temp     <= pwdata[15:0];
        REG_FAN_DELAY_MS:   cfg_q.fan_delay_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero-extended to the bus width.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TARGET_TEMP:    prdata = {16'd0, cfg_q.target_temp};
      REG_SWING_BAND:     prdata = {17'd0, cfg_q.swing_band};
      REG_REQUESTED_MODE: prdata = {30'd0, cfg_q.requested_mode};
      REG_FAN_FORCE:      prdata = {31'd0, cfg_q.fan_force};
      REG_FLOOR_TEMP:     prdata = {16'd0, cfg_q.floor_temp};
      REG_FAN_DELAY_MS:   prdata = {16'd0, cfg_q.fan_delay_ms};
      default:            prdata = '0;
    endcase
  end

endmodule

// File: hdl/thc_in_stage.sv
`timescale 1ns / 1ps

module thc_in_stage
  import thc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] temperature_i,
  input  logic [31:0]        now_ms_i,
  input  logic               advance_i,
  output logic               beat_valid_o,
  output in_beat_t           beat_o
);

  logic     valid_q;
  logic     valid_d;
  logic     accept;
  in_beat_t beat_q;

  // The register stalls only when it holds a beat the core cannot take.
  assign in_stall_o   = valid_q & ~advance_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q.temperature <= temperature_i;
      beat_q.now_ms      <= now_ms_i;
    end
  end

endmodule

// File: hdl/thc_core.sv
`timescale 1ns / 1ps

module thc_core
  import thc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     beat_valid_i,
  input  in_beat_t beat_i,
  output logic     advance_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output logic     hvac_enable_o,
  output logic     select_cool_o,
  output logic     fan_drive_o,
  output logic     fan_on_ind_o,
  output logic     fan_auto_ind_o,
  output logic     heat_ind_o,
  output logic     cool_ind_o,
  output logic     led_off_o,
  output logic     status_changed_o
);

  // Controller state.
  mode_e       active_mode_q, active_mode_d;
  logic        fan_state_q, fan_state_d;
  logic [31:0] delay_end_q, delay_end_d;
  logic        sel_hold_q, sel_hold_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic        hvac_enable_q, hvac_enable_d;
  logic        changed_q, changed_d;
  mode_e       req_mode_q;
  logic        fan_force_q;

  logic               step;
  logic signed [17:0] temp_x, lo_x, hi_x, floor_x;
  logic               below_floor, below_lo, at_hi;
  logic               go;
  mode_e              mode_sel;
  logic               mode_chg, arm;
  logic [31:0]        delay_sum, delay_diff;
  logic               delay_done;
  logic [3:0]         fan_idx;
  logic               fan_chg;

  assign advance_o = ~out_valid_q | ~out_stall_i;
  assign step      = beat_valid_i & advance_o;

  // Hysteresis band edges, formed wide so they never wrap.
  assign temp_x      = 18'(beat_i.temperature);
  assign floor_x     = 18'(cfg_i.floor_temp);
  assign lo_x        = 18'(cfg_i.target_temp) - $signed({3'd0, cfg_i.swing_band});
  assign hi_x        = 18'(cfg_i.target_temp) + $signed({3'd0, cfg_i.swing_band});
  assign below_floor = temp_x < floor_x;
  assign below_lo    = temp_x < lo_x;
  assign at_hi       = temp_x >= hi_x;

  // Mode decision; an invalid request leaves the active mode alone unless the temperature is below the floor.
  always_comb begin
    go       = 1'b1;
    mode_sel = MODE_OFF;
    if (below_floor) begin
      mode_sel = MODE_HEAT;
    end else begin
      unique case (cfg_i.requested_mode)
        MODE_HEAT: begin
          if (below_lo) begin
            mode_sel = MODE_HEAT;
          end else if (at_hi) begin
            mode_sel = MODE_OFF;
          end else begin
            mode_sel = (active_mode_q == MODE_HEAT) ? MODE_HEAT : MODE_OFF;
          end
        end
        MODE_COOL: begin
          if (at_hi) begin
            mode_sel = MODE_COOL;
          end else if (below_lo) begin
            mode_sel = MODE_OFF;
          end else begin
            mode_sel = (active_mode_q == MODE_COOL) ? MODE_COOL : MODE_OFF;
          end
        end
        MODE_OFF: mode_sel = MODE_OFF;
        default: begin
          go       = 1'b0;
          mode_sel = active_mode_q;
        end
      endcase
    end
  end

  assign mode_chg      = go & (mode_sel != active_mode_q);
  assign arm           = mode_chg & (mode_sel != MODE_OFF);
  assign active_mode_d = mode_sel;

  // Fan delay: a fresh arm is over only when the delay is zero and the end
  // time did not land on zero (which is stored as one).
  assign delay_sum   = beat_i.now_ms + {16'd0, cfg_i.fan_delay_ms};
  assign delay_diff  = beat_i.now_ms - delay_end_q;
  assign delay_end_d = arm ? ((delay_sum == 32'd0) ? 32'd1 : delay_sum) : delay_end_q;
  assign delay_done  = arm ? ((cfg_i.fan_delay_ms == 16'd0) && (beat_i.now_ms != 32'd0))
                           : ~delay_diff[31];

  always_comb begin
    sel_hold_d = sel_hold_q;
    if (mode_sel == MODE_HEAT) begin
      sel_hold_d = 1'b0;
    end else if (mode_sel == MODE_COOL) begin
      sel_hold_d = 1'b1;
    end
  end

  assign hvac_enable_d = (active_mode_d != MODE_OFF);
  assign fan_idx       = {fan_state_q, hvac_enable_d, cfg_i.fan_force, delay_done};

  // Fan table on {last fan, enabled, forced, delay over}.
  always_comb begin
    case (fan_idx)
      4'd8, 4'd9: begin
        fan_state_d = 1'b0;
        fan_chg     = 1'b1;
      end
      4'd0, 4'd1, 4'd4, 4'd6: begin
        fan_state_d = 1'b0;
        fan_chg     = 1'b0;
      end
      4'd2, 4'd3, 4'd5, 4'd7: begin
        fan_state_d = 1'b1;
        fan_chg     = 1'b1;
      end
      default: begin
        fan_state_d = 1'b1;
        fan_chg     = 1'b0;
      end
    endcase
  end

  assign changed_d = mode_chg | fan_chg;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_mode_q <= MODE_OFF;
      fan_state_q   <= 1'b0;
      delay_end_q   <= '0;
      sel_hold_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        active_mode_q <= active_mode_d;
        fan_state_q   <= fan_state_d;
        delay_end_q   <= delay_end_d;
        sel_hold_q    <= sel_hold_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      hvac_enable_q <= hvac_enable_d;
      changed_q     <= changed_d;
      req_mode_q    <= cfg_i.requested_mode;
      fan_force_q   <= cfg_i.fan_force;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hvac_enable_o    = hvac_enable_q;
  assign select_cool_o    = sel_hold_q;
  assign fan_drive_o      = fan_state_q;
  assign fan_on_ind_o     = fan_force_q;
  assign fan_auto_ind_o   = ~fan_force_q;
  assign heat_ind_o       = (req_mode_q == MODE_HEAT);
  assign cool_ind_o       = (req_mode_q == MODE_COOL);
  assign led_off_o        = (req_mode_q == MODE_OFF);
  assign status_changed_o = changed_q;

endmodule

// File: hdl/thermostat_hysteresis_controller.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i/in_stall_o    temperature_i, now_ms_i
// out       source     out_valid_o/out_stall_i  hvac_enable_o .. status_changed_o
// cfg       APB slave  psel/penable/pready      paddr, pwdata, prdata
//
// One beat per cycle is accepted while the result is not stalled; each beat
// passes the input register, then the result register, where its result is
// presented on the out channel.
// The mode, fan delay and fan table are evaluated combinationally between them.
// Reset is asynchronous and active low; it clears the state to mode off.
// A stalled result holds the input register, which then stalls the input.

module thermostat_hysteresis_controller
  import thc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   temperature_i,
  input  logic [31:0]          now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hvac_enable_o,
  output logic                 select_cool_o,
  output logic                 fan_drive_o,
  output logic                 fan_on_ind_o,
  output logic                 fan_auto_ind_o,
  output logic                 heat_ind_o,
  output logic                 cool_ind_o,
  output logic                 led_off_o,
  output logic                 status_changed_o
);

  cfg_t     cfg;
  logic     beat_valid;
  in_beat_t beat;
  logic     advance;

  thc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  thc_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .temperature_i (temperature_i),
    .now_ms_i      (now_ms_i),
    .advance_i     (advance),
    .beat_valid_o  (beat_valid),
    .beat_o        (beat)
  );

  thc_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .beat_valid_i     (beat_valid),
    .beat_i           (beat),
    .advance_o        (advance),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hvac_enable_o    (hvac_enable_o),
    .select_cool_o    (select_cool_o),
    .fan_drive_o      (fan_drive_o),
    .fan_on_ind_o     (fan_on_ind_o),
    .fan_auto_ind_o   (fan_auto_ind_o),
    .heat_ind_o       (heat_ind_o),
    .cool_ind_o       (cool_ind_o),
    .led_off_o        (led_off_o),
    .status_changed_o (status_changed_o)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb
  import thc_pkg::*;
();

  // One result beat, in the order of the output ports.
  typedef struct packed {
    logic hvac_enable;
    logic select_cool;
    logic fan_drive;
    logic fan_on_ind;
    logic fan_auto_ind;
    logic heat_ind;
    logic cool_ind;
    logic led_off;
    logic status_changed;
  } result_t;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 10;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [15:0]   temperature_i = '0;
  logic [31:0]          now_ms_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 hvac_enable_o;
  logic                 select_cool_o;
  logic                 fan_drive_o;
  logic                 fan_on_ind_o;
  logic                 fan_auto_ind_o;
  logic                 heat_ind_o;
  logic                 cool_ind_o;
  logic                 led_off_o;
  logic                 status_changed_o;

  thermostat_hysteresis_controller i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .temperature_i   (temperature_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hvac_enable_o   (hvac_enable_o),
    .select_cool_o   (select_cool_o),
    .fan_drive_o     (fan_drive_o),
    .fan_on_ind_o    (fan_on_ind_o),
    .fan_auto_ind_o  (fan_auto_ind_o),
    .heat_ind_o      (heat_ind_o),
    .cool_ind_o      (cool_ind_o),
    .led_off_o       (led_off_o),
    .status_changed_o(status_changed_o)
  );

  // Shadow copy of the register file.
  int          cfg_target = 0;
  int          cfg_band = 0;
  mode_e       cfg_mode = MODE_OFF;
  logic        cfg_force = 1'b0;
  int          cfg_min = int'(FloorTempReset);
  logic [15:0] cfg_delay = FanDelayMsReset;

  // Shadow copy of the controller state.
  mode_e       st_mode = MODE_OFF;
  logic        st_fan = 1'b0;
  logic [31:0] st_delay_end = '0;
  logic        st_sel_cool = 1'b0;

  in_beat_t pending_ticks[$];
  result_t  due_outputs[$];
  in_beat_t beat;
  result_t  got;
  result_t  want;
  logic     steady = 1'b0;
  int       in_gap = 0;
  int       stall_left = 0;
  int       idle_cycles = 0;
  int       n_ticks = 0;
  int       n_checked = 0;
  int       n_mismatch = 0;
  int       n_settings = 0;
  int       n_heat_entries = 0;
  int       n_cool_entries = 0;
  int       n_fan_starts = 0;

  // Random idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Switch the active mode; a real change into heat or cool arms the fan delay.
  function automatic logic enter_mode(mode_e m, logic [31:0] now);
    logic moved;
    moved = (st_mode != m);
    if (moved && m != MODE_OFF) begin
      st_delay_end = now + {16'b0, cfg_delay};
      // A delay end of zero reads as unarmed, so it is nudged to one.
      if (st_delay_end == '0) begin
        st_delay_end = 32'd1;
      end
      if (m == MODE_HEAT) begin
        n_heat_entries++;
      end else begin
        n_cool_entries++;
      end
    end
    st_mode = m;
    if (m == MODE_HEAT) begin
      st_sel_cool = 1'b0;
    end else if (m == MODE_COOL) begin
      st_sel_cool = 1'b1;
    end
    return moved;
  endfunction

  // Evaluate one tick against the shadow state and return the expected outputs.
  function automatic result_t thermostat_tick(logic signed [15:0] temp, logic [31:0] now);
    int          t;
    int          lo;
    int          hi;
    logic        chg;
    logic        en;
    logic        done;
    logic [31:0] since;
    result_t     r;
    t = temp;
    lo = cfg_target - cfg_band;
    hi = cfg_target + cfg_band;
    chg = 1'b0;
    // Inside the band a mode is only kept, never entered, so anything else drops to off.
    if (t < cfg_min) begin
      chg = enter_mode(MODE_HEAT, now);
    end else if (cfg_mode == MODE_HEAT) begin
      if (t < lo) begin
        chg = enter_mode(MODE_HEAT, now);
      end else if (t >= hi || st_mode != MODE_HEAT) begin
        chg = enter_mode(MODE_OFF, now);
      end
    end else if (cfg_mode == MODE_COOL) begin
      if (t >= hi) begin
        chg = enter_mode(MODE_COOL, now);
      end else if (t < lo || st_mode != MODE_COOL) begin
        chg = enter_mode(MODE_OFF, now);
      end
    end else if (cfg_mode == MODE_OFF) begin
      chg = enter_mode(MODE_OFF, now);
    end

    // Fan table over {last fan, enabled, forced, delay over}.
    en = (st_mode != MODE_OFF);
    since = now - st_delay_end;
    done = ~since[31];
    case ({st_fan, en, cfg_force, done})
      4'b1000, 4'b1001: begin
        chg = 1'b1;
        st_fan = 1'b0;
      end
      4'b0000, 4'b0001, 4'b0100, 4'b0110: begin
        st_fan = 1'b0;
      end
      4'b0010, 4'b0011, 4'b0101, 4'b0111: begin
        chg = 1'b1;
        st_fan = 1'b1;
        n_fan_starts++;
      end
      default: begin
        st_fan = 1'b1;
      end
    endcase

    r.hvac_enable = en;
    r.select_cool = st_sel_cool;
    r.fan_drive = st_fan;
    r.fan_on_ind = cfg_force;
    r.fan_auto_ind = ~cfg_force;
    r.heat_ind = (cfg_mode == MODE_HEAT);
    r.cool_ind = (cfg_mode == MODE_COOL);
    r.led_off = (cfg_mode == MODE_OFF);
    r.status_changed = chg;
    return r;
  endfunction

  function automatic void add_tick(int temp, logic [31:0] now);
    in_beat_t b;
    b.temperature = 16'(temp);
    b.now_ms = now;
    pending_ticks.push_back(b);
  endfunction

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TARGET_TEMP:    cfg_target = int'($signed(value[15:0]));
      REG_SWING_BAND:     cfg_band = int'(value[14:0]);
      REG_REQUESTED_MODE: cfg_mode = mode_e'(value[1:0]);
      REG_FAN_FORCE:      cfg_force = value[0];
      REG_FLOOR_TEMP:     cfg_min = int'($signed(value[15:0]));
      REG_FAN_DELAY_MS:   cfg_delay = value[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int tgt, int band, mode_e mode, logic fan_forced, int mn,
                               int dly);
    write_reg(REG_TARGET_TEMP, 32'(tgt));
    write_reg(REG_SWING_BAND, 32'(band));
    write_reg(REG_REQUESTED_MODE, {30'b0, mode});
    write_reg(REG_FAN_FORCE, {31'b0, fan_forced});
    write_reg(REG_FLOOR_TEMP, 32'(mn));
    write_reg(REG_FAN_DELAY_MS, 32'(dly));
    n_settings++;
  endtask

  // Wait until every queued tick has been sent and every result has come back.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || due_outputs.size() != 0);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Input driver: predicts each accepted beat, then presents the next tick.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        due_outputs.push_back(thermostat_tick(temperature_i, now_ms_i));
        n_ticks++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          beat = pending_ticks.pop_front();
          temperature_i <= beat.temperature;
          now_ms_i <= beat.now_ms;
          in_valid_i <= 1'b1;
          if (!steady) begin
            in_gap = pick_gap();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each accepted beat and drives random stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {hvac_enable_o, select_cool_o, fan_drive_o, fan_on_ind_o, fan_auto_ind_o,
               heat_ind_o, cool_ind_o, led_off_o, status_changed_o};
        if (due_outputs.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("Unexpected result beat %b with nothing outstanding", got);
          end
        end else begin
          want = due_outputs.pop_front();
          n_checked++;
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("Result %0d (exp/got): hvac %b/%b sel_cool %b/%b fan %b/%b",
                       n_checked, want.hvac_enable, got.hvac_enable, want.select_cool,
                       got.select_cool, want.fan_drive, got.fan_drive);
              $display("  fan_on %b/%b fan_auto %b/%b heat %b/%b cool %b/%b",
                       want.fan_on_ind, got.fan_on_ind, want.fan_auto_ind,
                       got.fan_auto_ind, want.heat_ind, got.heat_ind, want.cool_ind,
                       got.cool_ind);
              $display("  led_off %b/%b changed %b/%b", want.led_off, got.led_off,
                       want.status_changed, got.status_changed);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!steady) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Timeout: no transfer for %0d cycles", StallLimit);
      $display("** thermostat_hysteresis_controller: FAILED **");
      $finish;
    end
  end

  // Stimulus: a directed opening, then random settings with tick sequences.
  initial begin
    int          tgt;
    int          band;
    int          mn;
    int          dly;
    int          center;
    int          r;
    mode_e       mode;
    logic [31:0] now;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: field extremes with the controller off.
    add_tick(-32768, 32'h0000_0000);
    add_tick(32767, 32'hFFFF_FFFF);
    drain();

    // Heat entry whose delay end wraps to zero, band edges and the min rule.
    apply_setting(100, 10, MODE_HEAT, 1'b0, -100, 30000);
    add_tick(0, 32'hFFFF_8AD0);
    add_tick(95, 32'd0);
    add_tick(95, 32'd1);
    add_tick(110, 32'd2);
    add_tick(-101, 32'd5);
    add_tick(-32768, 32'd6);
    add_tick(89, 32'h8000_0000);
    drain();

    // Cool with zero delay and forced fan; min at its top forces heat.
    apply_setting(-32768, 32767, MODE_COOL, 1'b1, 32767, 0);
    add_tick(32767, 32'd100);
    add_tick(0, 32'd101);
    add_tick(32767, 32'd102);
    drain();

    // Forced fan held off while the longest delay runs, then released.
    apply_setting(32767, 32767, MODE_HEAT, 1'b1, -32768, 65535);
    add_tick(-1, 32'd200);
    add_tick(32767, 32'd300);
    add_tick(0, 32'd65735);
    add_tick(-32768, 32'd65736);
    drain();

    // Invalid mode keeps the active mode apart from the min rule.
    apply_setting(0, 0, MODE_INVALID, 1'b0, 0, 30000);
    add_tick(5, 32'd10);
    add_tick(-1, 32'd11);
    add_tick(32767, 32'd12);
    drain();

    apply_setting(0, 0, MODE_OFF, 1'b0, -32768, 1);
    add_tick(0, 32'd20);
    add_tick(100, 32'd21);
    drain();

    // Random settings, each followed by a walk of ticks around the band.
    for (int ph = 0; ph < 9; ph++) begin
      r = $urandom_range(0, 7);
      tgt = (r == 0) ? 32767 : (r == 1) ? -32768 : int'($urandom_range(0, 600)) - 300;
      r = $urandom_range(0, 9);
      band = (r == 0) ? 0 : (r == 1) ? 32767 : int'($urandom_range(1, 25));
      r = $urandom_range(0, 9);
      mode = (r < 4) ? MODE_HEAT : (r < 8) ? MODE_COOL : (r < 9) ? MODE_OFF : MODE_INVALID;
      r = $urandom_range(0, 9);
      if (r < 4) begin
        mn = -32768;
      end else if (r < 8) begin
        mn = clamp16(tgt - band - int'($urandom_range(0, 30)));
      end else if (r < 9) begin
        mn = 32767;
      end else begin
        mn = int'($signed(16'($urandom)));
      end
      r = $urandom_range(0, 9);
      dly = (r == 0) ? 0 : (r == 1) ? 65535 : int'($urandom_range(1, 400));
      apply_setting(tgt, band, mode, 1'($urandom_range(0, 1)), mn, dly);

      steady = (ph % 3 == 2);
      now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
      repeat (66) begin
        center = ($urandom_range(0, 3) == 0) ? cfg_min : cfg_target;
        if ($urandom_range(0, 9) == 0) begin
          add_tick(int'($signed(16'($urandom))), now);
        end else begin
          add_tick(clamp16(center + int'($urandom_range(0, 2 * (cfg_band + 40))) -
                           (cfg_band + 40)), now);
        end
        now = ($urandom_range(0, 29) == 0) ? $urandom : now + $urandom_range(0, 40);
      end
      drain();
      steady = 1'b0;
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (due_outputs.size() != 0) begin
      $display("%0d expected results never arrived", due_outputs.size());
      n_mismatch += due_outputs.size();
    end
    $display("Ran %0d ticks under %0d register settings; %0d results checked, %0d bad.",
             n_ticks, n_settings, n_checked, n_mismatch);
    $display("Predicted %0d heat entries, %0d cool entries and %0d fan starts.",
             n_heat_entries, n_cool_entries, n_fan_starts);
    if (n_mismatch == 0) begin
      $display("** thermostat_hysteresis_controller: PASSED **");
    end else begin
      $display("** thermostat_hysteresis_controller: FAILED **");
    end
    $finish;
  end

endmodule
